### rtl/xoshiro_pkg.sv
// xoshiro_pkg: command codes, state word type, constants and step function
// for the xoshiro256+ generator; used by xoshiro_ctrl, xoshiro_dp and the top level
package xoshiro_pkg;

    localparam logic [2:0] CMD_NEXT      = 3'd0;
    localparam logic [2:0] CMD_SEED      = 3'd1;
    localparam logic [2:0] CMD_JUMP      = 3'd2;
    localparam logic [2:0] CMD_LONG_JUMP = 3'd3;
    localparam logic [2:0] CMD_READ      = 3'd4;
    localparam logic [2:0] CMD_WRITE     = 3'd5;

    localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2   = 64'h94d049bb133111eb;

    // bit w*64+b of each polynomial is bit b of word w
    localparam logic [255:0] JUMP_POLY = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
    };
    localparam logic [255:0] LONG_JUMP_POLY = {
        64'h39109bb02acbe69d, 64'h77710069854ee241,
        64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
    };

    typedef logic [3:0][63:0] words_t;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_SEED_ADD = 4'b0010,
        S_MUL      = 4'b0100,
        S_LEAP     = 4'b1000
    } ctrl_state_t;

    typedef struct packed {
        logic       accept;
        logic       seed_add;
        logic       mul_active;
        logic [1:0] mul_phase;
        logic       mul_second;
        logic [1:0] word_sel;
        logic       leap_step;
        logic       leap_take;
        logic       leap_last;
    } dp_cmd_t;

    function automatic words_t xoshiro_advance(input words_t s);
        words_t n;
        logic [63:0] t3;
        t3   = s[3] ^ s[1];
        n[2] = s[2] ^ s[0] ^ (s[1] << 17);
        n[1] = s[1] ^ s[2] ^ s[0];
        n[0] = s[0] ^ t3;
        n[3] = {t3[18:0], t3[63:19]};
        return n;
    endfunction

endpackage

### rtl/xoshiro_ctrl.sv
// xoshiro_ctrl: handshake control and sequencer for seeding and jumps
// depends on xoshiro_pkg; drives xoshiro_dp through a dp_cmd_t struct
module xoshiro_ctrl
    import xoshiro_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] command,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic        second_reg, second_next;
    logic [1:0]  word_reg, word_next;
    logic [7:0]  step_reg, step_next;
    logic        long_reg, long_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;
    logic [255:0] poly;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign poly      = long_reg ? LONG_JUMP_POLY : JUMP_POLY;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        second_next    = second_reg;
        word_next      = word_reg;
        step_next      = step_reg;
        long_next      = long_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        // every word gets its result at once, so the output never waits on the sequencer
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_SEED:
                        begin
                            state_next = S_SEED_ADD;
                            word_next  = 2'd0;
                        end
                        CMD_JUMP:
                        begin
                            state_next = S_LEAP;
                            step_next  = 8'd0;
                            long_next  = 1'b0;
                        end
                        CMD_LONG_JUMP:
                        begin
                            state_next = S_LEAP;
                            step_next  = 8'd0;
                            long_next  = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEED_ADD:
            begin
                state_next  = S_MUL;
                phase_next  = 2'd0;
                second_next = 1'b0;
            end
            S_MUL:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    if (!second_reg)
                    begin
                        second_next = 1'b1;
                    end
                    else if (word_reg == 2'd3)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        word_next  = word_reg + 2'd1;
                        state_next = S_SEED_ADD;
                    end
                end
            end
            S_LEAP:
            begin
                step_next = step_reg + 8'd1;
                if (step_reg == 8'hFF)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = accept;
        cmd.seed_add   = (state_reg == S_SEED_ADD);
        cmd.mul_active = (state_reg == S_MUL);
        cmd.mul_phase  = phase_reg;
        cmd.mul_second = second_reg;
        cmd.word_sel   = word_reg;
        cmd.leap_step  = (state_reg == S_LEAP);
        cmd.leap_take  = poly[step_reg];
        cmd.leap_last  = (step_reg == 8'hFF);
    end

    // reset starts the seed-zero expansion straight away
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SEED_ADD;
            phase_reg     <= 2'd0;
            second_reg    <= 1'b0;
            word_reg      <= 2'd0;
            step_reg      <= 8'd0;
            long_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            second_reg    <= second_next;
            word_reg      <= word_next;
            step_reg      <= step_next;
            long_reg      <= long_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE))
        else $error("ready raised while sequencer busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == CMD_JUMP || command == CMD_LONG_JUMP))
        |=> (state_reg == S_LEAP && step_reg == 8'd0))
        else $error("jump did not start at step zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEAP && step_reg == 8'hFF) |=> (state_reg == S_IDLE))
        else $error("jump did not end after the last step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && phase_reg == 2'd3 && second_reg && word_reg == 2'd3)
        |=> (state_reg == S_IDLE))
        else $error("seed expansion did not end after the fourth word");

endmodule

### rtl/xoshiro_dp.sv
// xoshiro_dp: state words, shared 32x32 multiplier for splitmix64, jump accumulator
// and output register; depends on xoshiro_pkg, controlled by xoshiro_ctrl
module xoshiro_dp
    import xoshiro_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [2:0]  command,
    input  logic [63:0] data_value,
    input  logic [1:0]  word_index,
    output logic [63:0] random_value,
    output logic [52:0] unit_fraction
);

    words_t      words_reg, words_next;
    words_t      leap_acc_reg, leap_acc_next;
    logic [63:0] seed_acc_reg, seed_acc_next;
    logic [63:0] m_reg, m_next;
    logic [63:0] prod_reg;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] out_value_reg, out_value_next;
    logic [63:0] seed_sum;
    logic [63:0] mul_b;
    logic [31:0] a_half, b_half;
    logic [63:0] prod_full;
    logic [63:0] mul_result;

    assign random_value  = out_value_reg;
    assign unit_fraction = out_value_reg[63:11];

    // low 64 bits of m * b from three partial products, one per cycle
    assign mul_b      = cmd.mul_second ? SM_MUL2 : SM_MUL1;
    assign a_half     = (cmd.mul_phase == 2'd2) ? m_reg[63:32] : m_reg[31:0];
    assign b_half     = (cmd.mul_phase == 2'd1) ? mul_b[63:32] : mul_b[31:0];
    assign prod_full  = 64'(a_half) * 64'(b_half);
    assign mul_result = sum_reg + {prod_reg[31:0], 32'h0};
    assign seed_sum   = seed_acc_reg + SM_GOLDEN;

    always_comb
    begin
        words_next     = words_reg;
        leap_acc_next  = leap_acc_reg;
        seed_acc_next  = seed_acc_reg;
        m_next         = m_reg;
        sum_next       = sum_reg;
        out_value_next = out_value_reg;

        if (cmd.accept)
        begin
            out_value_next = 64'h0;
            leap_acc_next  = '0;
            case (command)
                CMD_NEXT:
                begin
                    out_value_next = words_reg[0] + words_reg[3];
                    words_next     = xoshiro_advance(words_reg);
                end
                CMD_SEED:
                begin
                    seed_acc_next = data_value;
                end
                CMD_READ:
                begin
                    out_value_next = words_reg[word_index];
                end
                CMD_WRITE:
                begin
                    words_next[word_index] = data_value;
                end
                default:
                begin
                    out_value_next = 64'h0;
                end
            endcase
        end

        if (cmd.seed_add)
        begin
            seed_acc_next = seed_sum;
            m_next        = seed_sum ^ (seed_sum >> 30);
        end

        if (cmd.mul_active)
        begin
            case (cmd.mul_phase)
                2'd1:
                begin
                    sum_next = prod_reg;
                end
                2'd2:
                begin
                    sum_next = mul_result;
                end
                2'd3:
                begin
                    if (!cmd.mul_second)
                    begin
                        m_next = mul_result ^ (mul_result >> 27);
                    end
                    else
                    begin
                        words_next[cmd.word_sel] = mul_result ^ (mul_result >> 31);
                    end
                end
                default:
                begin
                    sum_next = sum_reg;
                end
            endcase
        end

        // gather state where the poly bit is set, then step, or at the end load it
        if (cmd.leap_step)
        begin
            if (cmd.leap_take)
            begin
                leap_acc_next = leap_acc_reg ^ words_reg;
            end
            if (cmd.leap_last)
            begin
                words_next = leap_acc_next;
            end
            else
            begin
                words_next = xoshiro_advance(words_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_acc_reg <= 64'h0;
        end
        else
        begin
            seed_acc_reg <= seed_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg     <= words_next;
        leap_acc_reg  <= leap_acc_next;
        m_reg         <= m_next;
        prod_reg      <= prod_full;
        sum_reg       <= sum_next;
        out_value_reg <= out_value_next;
    end

endmodule

### rtl/xoshiro256plus_generator_top.sv
// xoshiro256plus_generator_top: xoshiro256+ generator with seeding, jumps and word access
// depends on xoshiro_pkg, xoshiro_ctrl and xoshiro_dp
//
//   channel  handshake             payload
//   in       in_valid / in_ready   command, data_value, word_index
//   out      out_valid / out_ready random_value, unit_fraction
//
// next, read and write words stream back to back while the output is not stalled
// seed runs four splitmix64 rounds, one per state word, on one shared 32x32 multiplier
// jump and long jump handle one polynomial bit per generator step over all 256 bits
// after reset the seed-zero expansion runs with in_ready low
// the result of every word is registered at acceptance; a stalled output holds in_ready low
module xoshiro256plus_generator_top
    import xoshiro_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [63:0] data_value,
    input  logic [1:0]  word_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] random_value,
    output logic [52:0] unit_fraction
);

    dp_cmd_t cmd;

    xoshiro_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    xoshiro_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .command       (command),
        .data_value    (data_value),
        .word_index    (word_index),
        .random_value  (random_value),
        .unit_fraction (unit_fraction)
    );

endmodule

### test/xoshiro256plus_generator_top_tb.sv
// xoshiro256plus_generator_top_tb: drives command words into the generator and checks
// every result word against its own xoshiro256+ prediction; uses xoshiro_pkg for codes
// and the jump polynomials, and needs nothing but the rtl
module xoshiro256plus_generator_top_tb;
    import xoshiro_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_SPARE_LO   = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI   = 3'd7;
    localparam int         RANDOM_WORDS   = 700;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [63:0] value;
        logic [52:0] fraction;
    } gen_result_t;

    class xoshiro_scoreboard;
        logic [63:0] gen_words [4];
        gen_result_t awaited_q [$];
        int          fail_count;

        function new();
            fail_count = 0;
            seed_words(64'd0);
        endfunction

        function logic [63:0] step_words();
            logic [63:0] sum;
            logic [63:0] shifted;
            sum          = gen_words[0] + gen_words[3];
            shifted      = gen_words[1] << 17;
            gen_words[2] = gen_words[2] ^ gen_words[0];
            gen_words[3] = gen_words[3] ^ gen_words[1];
            gen_words[1] = gen_words[1] ^ gen_words[2];
            gen_words[0] = gen_words[0] ^ gen_words[3];
            gen_words[2] = gen_words[2] ^ shifted;
            gen_words[3] = (gen_words[3] << 45) | (gen_words[3] >> 19);
            return sum;
        endfunction

        // four splitmix64 rounds, one per state word
        function void seed_words(logic [63:0] seed);
            logic [63:0] acc;
            logic [63:0] mix;
            acc = seed;
            for (int w = 0; w < 4; w++)
            begin
                acc          = acc + SM_GOLDEN;
                mix          = (acc ^ (acc >> 30)) * SM_MUL1;
                mix          = (mix ^ (mix >> 27)) * SM_MUL2;
                gen_words[w] = mix ^ (mix >> 31);
            end
        endfunction

        function void leap_words(logic [255:0] poly);
            logic [63:0] acc [4];
            logic [63:0] unused_out;
            for (int j = 0; j < 4; j++)
                acc[j] = 64'd0;
            for (int i = 0; i < 256; i++)
            begin
                if (poly[i])
                begin
                    for (int j = 0; j < 4; j++)
                        acc[j] = acc[j] ^ gen_words[j];
                end
                unused_out = step_words();
            end
            for (int j = 0; j < 4; j++)
                gen_words[j] = acc[j];
        endfunction

        function void note_word(logic [2:0] cmd, logic [63:0] data, logic [1:0] idx);
            gen_result_t res;
            res.value = 64'd0;
            case (cmd)
                CMD_NEXT:      res.value = step_words();
                CMD_SEED:      seed_words(data);
                CMD_JUMP:      leap_words(JUMP_POLY);
                CMD_LONG_JUMP: leap_words(LONG_JUMP_POLY);
                CMD_READ:      res.value = gen_words[idx];
                CMD_WRITE:     gen_words[idx] = data;
                default:       res.value = 64'd0;
            endcase
            res.fraction = res.value[63:11];
            awaited_q.push_back(res);
        endfunction

        function void check_result(logic [63:0] value, logic [52:0] fraction);
            gen_result_t res;
            if (awaited_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("result word with nothing awaited: value %h fraction %h",
                             value, fraction);
                return;
            end
            res = awaited_q.pop_front();
            if (value !== res.value || fraction !== res.fraction)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("mismatch: expected value %h fraction %h, got value %h fraction %h",
                             res.value, res.fraction, value, fraction);
            end
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [63:0] data_value;
    logic [1:0]  word_index;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] random_value;
    logic [52:0] unit_fraction;

    xoshiro_scoreboard sb = new();
    bit                long_hold_req = 1'b0;
    int                idle_cycles = 0;

    xoshiro256plus_generator_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .data_value   (data_value),
        .word_index   (word_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .random_value (random_value),
        .unit_fraction(unit_fraction)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // output is checked before the input is noted: a word accepted at this edge
    // cannot already have its result on the output
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(random_value, unit_fraction);
            if (in_valid && in_ready)
                sb.note_word(command, data_value, word_index);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: changing stall patterns, plus one long hold-off on request
    initial
    begin
        int       mode;
        int       mode_left;
        int       phase;
        logic [7:0] pattern;
        out_ready <= 1'b0;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        pattern   = 8'hff;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                long_hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                    pattern   = 8'($urandom_range(1, 255));
                end
                mode_left--;
                phase = (phase + 1) % 8;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= pattern[phase];
                endcase
            end
        end
    end

    task automatic send_word(logic [2:0] cmd, logic [63:0] data, logic [1:0] idx);
        in_valid   <= 1'b1;
        command    <= cmd;
        data_value <= data;
        word_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [63:0] rand_data();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return {64{1'b1}};
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [2:0] rand_command();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)      return CMD_NEXT;
        else if (pick < 65) return CMD_READ;
        else if (pick < 80) return CMD_WRITE;
        else if (pick < 88) return CMD_SEED;
        else if (pick < 91) return CMD_JUMP;
        else if (pick < 93) return CMD_LONG_JUMP;
        else if (pick < 97) return CMD_SPARE_LO;
        else                return CMD_SPARE_HI;
    endfunction

    initial
    begin
        int sent;
        int burst;
        int gap;
        bit hold_done;
        bit drain_done;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        command    <= CMD_NEXT;
        data_value <= 64'd0;
        word_index <= 2'd0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state, stepping, word access, seeding and both jumps
        for (int i = 0; i < 4; i++)
            send_word(CMD_READ, 64'd0, i[1:0]);
        send_word(CMD_NEXT, 64'd0, 2'd0);
        send_word(CMD_NEXT, 64'd0, 2'd3);
        send_word(CMD_WRITE, {64{1'b1}}, 2'd0);
        send_word(CMD_READ, 64'd0, 2'd0);
        send_word(CMD_NEXT, 64'd0, 2'd0);
        send_word(CMD_SEED, 64'd0, 2'd0);
        send_word(CMD_READ, 64'd0, 2'd3);
        send_word(CMD_SEED, {64{1'b1}}, 2'd1);
        send_word(CMD_NEXT, 64'd0, 2'd0);
        send_word(CMD_JUMP, 64'd0, 2'd0);
        send_word(CMD_NEXT, 64'd0, 2'd0);
        send_word(CMD_LONG_JUMP, 64'd0, 2'd0);
        send_word(CMD_READ, 64'd0, 2'd1);
        // unused codes answer zero and leave the state alone
        send_word(CMD_SPARE_LO, {$urandom, $urandom}, 2'd2);
        send_word(CMD_SPARE_HI, {64{1'b1}}, 2'd3);
        // all-zero state keeps producing zero
        for (int i = 0; i < 4; i++)
            send_word(CMD_WRITE, 64'd0, i[1:0]);
        send_word(CMD_NEXT, 64'd0, 2'd0);
        send_word(CMD_SEED, {$urandom, $urandom}, 2'd0);
        pause_until_drained();

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (!hold_done && sent >= 200)
            begin
                // long output stall while words keep coming: the block holds in_ready low
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
                repeat (40)
                begin
                    send_word(rand_command(), rand_data(), 2'($urandom_range(0, 3)));
                    sent++;
                end
            end
            else if (!drain_done && sent >= 420)
            begin
                drain_done = 1'b1;
                pause_until_drained();
            end
            else
            begin
                burst = $urandom_range(1, 16);
                for (int b = 0; b < burst; b++)
                    send_word(rand_command(), rand_data(), 2'($urandom_range(0, 3)));
                sent += burst;
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        pause_until_drained();
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            $display("results still awaited at the end: %0d", sb.pending());
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
